FILE: rtl/pstp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the packed swap table parser.
// No dependencies; imported by every module of the block.
package pstp_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [3:0] HEADER_LAST_INDEX = 4'hF;

    // Field kinds as reported on the result channel
    localparam logic [2:0] KIND_OFFSET  = 3'd0;
    localparam logic [2:0] KIND_COUNT   = 3'd1;
    localparam logic [2:0] KIND_SIZE    = 3'd2;
    localparam logic [2:0] KIND_REPEAT  = 3'd3;
    localparam logic [2:0] KIND_SKIP    = 3'd4;
    localparam logic [2:0] KIND_SUBREP  = 3'd5;
    localparam logic [2:0] KIND_ENTRIES = 3'd6;

    // Packed value length prefixes
    localparam logic [1:0] PFX_ONE     = 2'd0;
    localparam logic [1:0] PFX_TWO     = 2'd1;
    localparam logic [1:0] PFX_FOUR    = 2'd2;
    localparam logic [1:0] PFX_INVALID = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [31:0] value;
        logic [1:0]  swap_type;
        logic        error;
        logic        last;
    } out_item_t;

endpackage

FILE: rtl/pstp_front.sv
`timescale 1ns / 1ps
// Front end: takes table bytes, tracks header/entry/sub-entry framing and
// assembles packed values into finished field items. Depends on pstp_pkg.
module pstp_front
    import pstp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  in_item_t  in_item,
    output logic      push,
    output out_item_t push_item
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_OFFSET = 3'd1;
    localparam logic [2:0] PH_COUNT  = 3'd2;
    localparam logic [2:0] PH_SIZE   = 3'd3;
    localparam logic [2:0] PH_REPEAT = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_SUBREP = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [1:0]  bleft_reg, bleft_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  htype_reg, htype_next;
    logic [31:0] entries_reg, entries_next;
    logic [29:0] hsub_reg, hsub_next;
    logic [29:0] subs_reg, subs_next;
    logic        halted_reg, halted_next;

    logic        restart;
    logic        emit;
    logic        fin;
    logic [31:0] fin_val;
    logic [1:0]  prefix;
    logic [7:0]  b;
    logic [31:0] entries_dec;
    logic [29:0] subs_dec;
    out_item_t   res;

    assign restart     = in_item.first;
    assign b           = in_item.data_byte;
    assign prefix      = b[7:6];

    always_comb
    begin
        // a first byte restarts from the reset state, but running
        phase_next   = restart ? PH_HEADER : phase_reg;
        hidx_next    = restart ? 4'd0      : hidx_reg;
        bleft_next   = restart ? 2'd0      : bleft_reg;
        acc_next     = restart ? 32'd0     : acc_reg;
        htype_next   = restart ? 2'd0      : htype_reg;
        entries_next = restart ? 32'd0     : entries_reg;
        hsub_next    = restart ? 30'd0     : hsub_reg;
        subs_next    = restart ? 30'd0     : subs_reg;
        halted_next  = restart ? 1'b0      : halted_reg;
        emit         = 1'b0;
        fin          = 1'b0;
        fin_val      = '0;
        res          = '0;
        entries_dec  = '0;
        subs_dec     = '0;

        if (!halted_next)
        begin
            if (phase_next == PH_HEADER)
            begin
                if (hidx_next[3:2] == 2'b01)
                    entries_next = entries_next
                                   | ({24'd0, b} << {hidx_next[1:0], 3'b000});
                if (hidx_next == HEADER_LAST_INDEX)
                begin
                    emit             = 1'b1;
                    res.field_kind   = KIND_ENTRIES;
                    res.value        = entries_next;
                    if (entries_next == 32'd0)
                    begin
                        halted_next = 1'b1;
                        res.last    = 1'b1;
                    end
                    else
                        phase_next = PH_OFFSET;
                end
                else
                    hidx_next = hidx_next + 4'd1;
            end
            else if (bleft_next != 2'd0)
            begin
                acc_next   = {acc_next[23:0], b};
                bleft_next = bleft_next - 2'd1;
                if (bleft_next == 2'd0)
                begin
                    fin     = 1'b1;
                    fin_val = acc_next;
                end
            end
            else if (prefix == PFX_INVALID)
            begin
                halted_next    = 1'b1;
                emit           = 1'b1;
                res.field_kind = phase_next - 3'd1;
                res.error      = 1'b1;
                res.last       = 1'b1;
            end
            else
            begin
                if (phase_next == PH_SKIP)
                begin
                    acc_next   = {28'd0, b[3:0]};
                    htype_next = b[5:4];
                end
                else
                    acc_next = {26'd0, b[5:0]};
                if (prefix == PFX_ONE)
                begin
                    fin     = 1'b1;
                    fin_val = acc_next;
                end
                else
                    bleft_next = (prefix == PFX_TWO) ? 2'd1 : 2'd3;
            end

            if (fin)
            begin
                emit           = 1'b1;
                res.field_kind = phase_next - 3'd1;
                res.value      = fin_val;
                res.swap_type  = (phase_next == PH_SKIP) ? htype_next : 2'd0;
                entries_dec    = entries_next - 32'd1;
                subs_dec       = subs_next - 30'd1;
                unique case (phase_next)
                    PH_OFFSET: phase_next = PH_COUNT;
                    PH_COUNT:
                    begin
                        hsub_next  = fin_val[29:0];
                        phase_next = PH_SIZE;
                    end
                    PH_SIZE:   phase_next = PH_REPEAT;
                    PH_REPEAT:
                    begin
                        if (hsub_next == 30'd0 || fin_val == 32'd0)
                        begin
                            entries_next = entries_dec;
                            if (entries_dec == 32'd0)
                            begin
                                halted_next = 1'b1;
                                res.last    = 1'b1;
                            end
                            else
                                phase_next = PH_OFFSET;
                        end
                        else
                        begin
                            subs_next  = hsub_next;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:   phase_next = PH_SUBREP;
                    PH_SUBREP:
                    begin
                        subs_next = subs_dec;
                        if (subs_dec == 30'd0)
                        begin
                            entries_next = entries_dec;
                            if (entries_dec == 32'd0)
                            begin
                                halted_next = 1'b1;
                                res.last    = 1'b1;
                            end
                            else
                                phase_next = PH_OFFSET;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                    default:
                    begin
                        halted_next = 1'b1;
                        res.last    = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hidx_reg    <= 4'd0;
            bleft_reg   <= 2'd0;
            acc_reg     <= 32'd0;
            htype_reg   <= 2'd0;
            entries_reg <= 32'd0;
            hsub_reg    <= 30'd0;
            subs_reg    <= 30'd0;
            halted_reg  <= 1'b1;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            hidx_reg    <= hidx_next;
            bleft_reg   <= bleft_next;
            acc_reg     <= acc_next;
            htype_reg   <= htype_next;
            entries_reg <= entries_next;
            hsub_reg    <= hsub_next;
            subs_reg    <= subs_next;
            halted_reg  <= halted_next;
        end
    end

    assign push      = take && emit;
    assign push_item = res;

endmodule

FILE: rtl/pstp_fifo.sv
`timescale 1ns / 1ps
// Short register queue of finished field items between front and back.
// Depends on pstp_pkg for the item type.
module pstp_fifo
    import pstp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      pop,
    output out_item_t pop_item,
    output logic      empty,
    output logic      full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    out_item_t     mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/pstp_back.sv
`timescale 1ns / 1ps
// Back end: drains the queue into the output register and runs the
// result handshake. Depends on pstp_pkg for the item type.
module pstp_back
    import pstp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  out_item_t q_item,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    // refill whenever the register is empty or its item leaves this cycle
    assign q_pop      = !q_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/packed_swap_table_parser.sv
`timescale 1ns / 1ps
// Top level of the packed swap table parser.
// Depends on pstp_pkg, pstp_front, pstp_fifo and pstp_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one table byte per
//   item; in_item.first marks header byte 0 and restarts the parse at once.
//   Output channel (out_valid/out_ready/out_item) carries one finished
//   field per item: kind, value, swap type of skip fields, error and last.
//   Bytes that finish no field produce nothing on the output.
//   Throughput: one byte per cycle, limited only by the output side.
//   Path: the queue is written at the edge that accepts a field's final
//   byte; the output register, which drives out_valid, is loaded from the
//   queue once it is empty or its item is taken.
//   Reset: the parser is halted until a byte with first set arrives; the
//   queue and output register come up empty.
//   Receiver stall: fields collect in the queue (QUEUE_DEPTH items) plus
//   the output register; in_ready drops only once the queue is full, and
//   nothing is lost or duplicated.
module packed_swap_table_parser
    import pstp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      take;
    logic      push;
    out_item_t push_item;
    logic      pop;
    out_item_t pop_item;
    logic      q_empty;
    logic      q_full;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    pstp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_item   (in_item),
        .push      (push),
        .push_item (push_item)
    );

    pstp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    pstp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
